[rtl/core/pds_pkg.sv]
// Shared types, constants and helper functions for the pedometer step detector.
// Used by pedometer_step_detector; has no dependencies of its own.
package pds_pkg;

    // Window depth that the ring memory is built for by default.
    localparam int MAX_WINDOW_DEF = 64;

    // Widths of the fixed fields.
    localparam int ACCEL_W    = 16;
    localparam int NORM_W     = 17;
    localparam int BASELINE_W = 17;
    localparam int MARGIN_W   = 16;
    localparam int WSIZE_W    = 7;
    localparam int TOTAL_W    = 32;
    localparam int LEVEL_W    = 3;
    localparam int MOD15_W    = 4;
    localparam int BASE_SUM_W = BASELINE_W + 1;

    // Stream and configuration port widths.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = BASELINE_W;

    // Register reset values.
    localparam logic [BASELINE_W-1:0] BASELINE_RST = 17'd7424;
    localparam logic [MARGIN_W-1:0]   STEP_MARGIN_RST  = 16'd512;
    localparam logic [MARGIN_W-1:0]   REARM_MARGIN_RST = 16'd256;
    localparam logic [WSIZE_W-1:0]    WSIZE_RST = 7'd16;

    // Reward rule: one level per fifteen steps, capped.
    localparam logic [MOD15_W-1:0] STEPS_PER_LEVEL = 4'd15;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE     = 2'd0,
        CFG_STEP_MARGIN  = 2'd1,
        CFG_REARM_MARGIN = 2'd2,
        CFG_WINDOW_SIZE  = 2'd3
    } cfg_idx_t;

    // Magnitude of a two's complement sample; the most negative code gives 32768.
    function automatic logic [NORM_W-1:0] accel_mag(input logic [ACCEL_W-1:0] v);
        logic [NORM_W-1:0] ext;
        ext = {1'b0, v};
        if (v[ACCEL_W-1])
            return (NORM_W'(1) << ACCEL_W) - ext;
        else
            return ext;
    endfunction

endpackage

[rtl/core/pedometer_step_detector.sv]
// Pedometer step detector top level: L1 norm, moving-average window and step logic.
// Depends on pds_pkg for widths and constants and on pds_ram for the norm ring.
//
// Takes one acceleration sample per clock unless the output stalls, and delivers one
// result item per sample. The result is presented once the sample has passed the input
// stage and the output register. Throughput is one item per cycle while the output is
// not stalled: the sample's norm and the ring read are registered at acceptance, and
// the running sum, threshold tests and counters are updated as the item moves on and
// the result register loads. The ring is a RAM; a flag that is set once the ring
// position has wrapped makes entries not yet written read as zero, so reset and a
// window_size write clear it at once, with no clearing pass. The step and re-arm
// bounds are registered products of the configuration and settle in the cycle after
// a configuration write. A full output register stalls the input only once the
// stage in front of it is also occupied.
module pedometer_step_detector
    import pds_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Sample stream. s_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result stream. m_tdata: step_now [0], step_total [32:1],
    // happiness_level [35:33], zero padding [39:36].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int POS_W = $clog2(MAX_WINDOW);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = NORM_W + WIN_W;
    localparam int BND_W = BASE_SUM_W + WIN_W;

    // Configuration registers.
    logic [BASELINE_W-1:0] baseline_reg;
    logic [MARGIN_W-1:0]   step_margin_reg;
    logic [MARGIN_W-1:0]   rearm_margin_reg;
    logic [WSIZE_W-1:0]    window_size_reg;
    logic                  cfg_fire;
    logic                  window_wr;

    // Derived window length and bounds.
    logic [WIN_W-1:0]      win_n;
    logic [BASE_SUM_W-1:0] high_base;
    logic [BASE_SUM_W-1:0] low_base;
    logic [BND_W-1:0]      high_bound_reg;
    logic [BND_W-1:0]      low_bound_reg;

    // Ring position and fill flag.
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_cur;
    logic [POS_W-1:0]      pos_next;
    logic                  ring_full_reg;

    // Input stage.
    logic                  accept;
    logic [NORM_W-1:0]     norm_in;
    logic                  s1_valid_reg;
    logic [NORM_W-1:0]     s1_norm_reg;
    logic [POS_W-1:0]      s1_pos_reg;
    logic                  s1_old_valid_reg;
    logic                  s1_fwd_reg;
    logic [NORM_W-1:0]     s1_fwd_data_reg;
    logic                  s1_adv;
    logic [NORM_W-1:0]     ram_rd_data;
    logic [NORM_W-1:0]     old_norm;

    // Detector state.
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic                  disarmed_reg;
    logic                  disarmed_next;
    logic [TOTAL_W-1:0]    steps_reg;
    logic [TOTAL_W-1:0]    steps_next;
    logic [MOD15_W-1:0]    mod15_reg;
    logic [MOD15_W-1:0]    mod15_next;
    logic [LEVEL_W-1:0]    level_reg;
    logic [LEVEL_W-1:0]    level_next;
    logic                  step_hit;

    // Output register.
    logic                  m_tvalid_reg;
    logic                  out_free;
    logic                  out_step_reg;
    logic [TOTAL_W-1:0]    out_total_reg;
    logic [LEVEL_W-1:0]    out_level_reg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign window_wr = cfg_fire && (cfg_index == CFG_WINDOW_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg     <= BASELINE_RST;
            step_margin_reg  <= STEP_MARGIN_RST;
            rearm_margin_reg <= REARM_MARGIN_RST;
            window_size_reg  <= WSIZE_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_BASELINE:     baseline_reg     <= cfg_data;
                CFG_STEP_MARGIN:  step_margin_reg  <= cfg_data[MARGIN_W-1:0];
                CFG_REARM_MARGIN: rearm_margin_reg <= cfg_data[MARGIN_W-1:0];
                CFG_WINDOW_SIZE:  window_size_reg  <= cfg_data[WSIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // A window size of zero acts as one; sizes above the ring depth saturate.
    always_comb
    begin
        if (window_size_reg == '0)
            win_n = WIN_W'(1);
        else if (32'(window_size_reg) > 32'(MAX_WINDOW))
            win_n = WIN_W'(MAX_WINDOW);
        else
            win_n = WIN_W'(window_size_reg);
    end

    assign high_base = BASE_SUM_W'(baseline_reg) + BASE_SUM_W'(step_margin_reg);
    assign low_base  = BASE_SUM_W'(baseline_reg) + BASE_SUM_W'(rearm_margin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_bound_reg <= '0;
            low_bound_reg  <= '0;
        end
        else
        begin
            high_bound_reg <= BND_W'(high_base) * BND_W'(win_n);
            low_bound_reg  <= BND_W'(low_base) * BND_W'(win_n);
        end
    end

    // Handshake: the input stage frees up whenever it hands its item on.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    assign norm_in = accel_mag(s_tdata[15:0]) + accel_mag(s_tdata[31:16])
                   + accel_mag(s_tdata[47:32]);

    always_comb
    begin
        if (32'(pos_reg) >= 32'(win_n))
            pos_cur = '0;
        else
            pos_cur = pos_reg;
        if (32'(pos_cur) + 32'd1 >= 32'(win_n))
            pos_next = '0;
        else
            pos_next = POS_W'(32'(pos_cur) + 32'd1);
    end

    pds_ram #(
        .WIDTH (NORM_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_pos_reg),
        .wr_data (s1_norm_reg),
        .rd_en   (accept),
        .rd_addr (pos_cur),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // When the item ahead writes the entry being read in the same cycle, the
    // RAM output is stale and the written norm is taken instead. Until the
    // position wraps for the first time after a clear, every entry read is
    // one that has not been written yet.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_norm_reg      <= norm_in;
            s1_pos_reg       <= pos_cur;
            s1_old_valid_reg <= ring_full_reg;
            s1_fwd_reg       <= s1_adv && (s1_pos_reg == pos_cur);
            s1_fwd_data_reg  <= s1_norm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ring_full_reg <= 1'b0;
        end
        else if (window_wr)
        begin
            pos_reg       <= '0;
            ring_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            if (pos_next == '0)
            begin
                ring_full_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (s1_fwd_reg)
            old_norm = s1_fwd_data_reg;
        else if (s1_old_valid_reg)
            old_norm = ram_rd_data;
        else
            old_norm = '0;
    end

    // The outgoing entry is part of the sum, so the subtraction never wraps.
    assign sum_next = sum_reg - SUM_W'(old_norm) + SUM_W'(s1_norm_reg);
    assign step_hit = (BND_W'(sum_next) > high_bound_reg) && !disarmed_reg;

    always_comb
    begin
        steps_next    = steps_reg;
        mod15_next    = mod15_reg;
        level_next    = level_reg;
        disarmed_next = disarmed_reg;
        if (step_hit)
        begin
            steps_next    = steps_reg + TOTAL_W'(1);
            disarmed_next = 1'b1;
            if (mod15_reg + MOD15_W'(1) >= STEPS_PER_LEVEL)
            begin
                mod15_next = '0;
                if (level_reg < LEVEL_MAX)
                    level_next = level_reg + LEVEL_W'(1);
            end
            else
            begin
                mod15_next = mod15_reg + MOD15_W'(1);
            end
        end
        if (BND_W'(sum_next) < low_bound_reg)
            disarmed_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            disarmed_reg <= 1'b0;
            steps_reg    <= '0;
            mod15_reg    <= '0;
            level_reg    <= '0;
        end
        else if (window_wr)
        begin
            sum_reg <= '0;
        end
        else if (s1_adv)
        begin
            sum_reg      <= sum_next;
            disarmed_reg <= disarmed_next;
            steps_reg    <= steps_next;
            mod15_reg    <= mod15_next;
            level_reg    <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_step_reg  <= step_hit;
            out_total_reg <= steps_next;
            out_level_reg <= level_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_level_reg, out_total_reg, out_step_reg};

`ifndef SYNTHESIS
    a_level_capped: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_MAX)
        else $error("reward level above its cap");

    a_mod15_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod15_reg < STEPS_PER_LEVEL)
        else $error("step phase counter out of range");

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(win_n))
        else $error("ring position outside the active window");

    a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && step_hit && !window_wr) |=>
            (steps_reg == $past(steps_reg) + TOTAL_W'(1)))
        else $error("counted step did not advance the total");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(out_total_reg)))
        else $error("stalled result changed");
`endif

endmodule

[rtl/core/pds_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the norm ring of the pedometer step detector; no package dependencies.
module pds_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for pedometer_step_detector: streams acceleration samples,
// predicts each result item from its own model of the window and step logic, and
// checks every result. Depends on pds_pkg and the pedometer_step_detector RTL.
module testbench;
    import pds_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int WATCHDOG_CYCLES = 300000;
    localparam int IDLE_PCT        = 8;
    localparam int RING_DEPTH      = MAX_WINDOW_DEF;
    localparam int unsigned NORM_MAX    = 98304;
    localparam int unsigned LEVEL_STEPS = 15;
    localparam int unsigned LEVEL_CAP   = 5;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_ITEMS    = 1800;

    typedef struct packed {
        logic        step_now;
        logic [31:0] step_total;
        logic [2:0]  level;
    } step_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the configuration registers.
    logic [16:0] base_r;
    logic [15:0] stepm_r;
    logic [15:0] rearm_r;
    logic [6:0]  win_r;

    // Shadow of the detector state.
    int unsigned ring_norm [RING_DEPTH];
    int unsigned ring_pos;
    int unsigned win_sum;
    bit          disarmed;
    logic [31:0] step_count;
    int unsigned mod15;
    int unsigned reward;

    step_result_t pending_results[$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  steps_seen = 0;
    int  cfg_writes = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  hold_req = 0;

    pedometer_step_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int unsigned window_len();
        if (win_r == 0)
            return 1;
        if (win_r > RING_DEPTH)
            return RING_DEPTH;
        return win_r;
    endfunction

    function automatic int unsigned axis_mag(input logic [15:0] v);
        if (v[15])
            return 32'd65536 - {16'd0, v};
        return {16'd0, v};
    endfunction

    function automatic void clear_window();
        foreach (ring_norm[i])
            ring_norm[i] = 0;
        ring_pos = 0;
        win_sum = 0;
    endfunction

    // Advances the shadow state by one sample and returns the result it must produce.
    function automatic step_result_t predict_step(input logic [15:0] ax, ay, az);
        int unsigned n;
        int unsigned norm;
        int unsigned slot;
        longint unsigned hi_lim;
        longint unsigned lo_lim;
        step_result_t r;
        n = window_len();
        norm = axis_mag(ax) + axis_mag(ay) + axis_mag(az);
        slot = (ring_pos >= n) ? 0 : ring_pos;
        win_sum = win_sum - ring_norm[slot] + norm;
        ring_norm[slot] = norm;
        slot++;
        ring_pos = (slot >= n) ? 0 : slot;
        hi_lim = (longint'(base_r) + longint'(stepm_r)) * longint'(n);
        lo_lim = (longint'(base_r) + longint'(rearm_r)) * longint'(n);
        r.step_now = 1'b0;
        if (longint'(win_sum) > hi_lim && !disarmed)
        begin
            step_count++;
            disarmed = 1'b1;
            r.step_now = 1'b1;
            mod15++;
            if (mod15 >= LEVEL_STEPS)
            begin
                mod15 = 0;
                if (reward < LEVEL_CAP)
                    reward++;
            end
        end
        // The re-arm test follows the step test, so both can hold in one sample.
        if (longint'(win_sum) < lo_lim)
            disarmed = 1'b0;
        r.step_total = step_count;
        r.level = reward[2:0];
        return r;
    endfunction

    task automatic send_sample(input logic [15:0] ax, ay, az);
        cfg_valid <= 1'b0;
        if (tx_idle_en && $urandom_range(99, 0) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {az, ay, ax};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(predict_step(ax, ay, az));
        items_sent++;
    endtask

    function automatic logic [15:0] signed_axis(input int unsigned mag);
        if (mag >= 32768)
            return 16'h8000;
        if ($urandom_range(1, 0))
            return mag[15:0];
        return 16'(32'd0 - mag);
    endfunction

    // Sends a sample whose L1 norm is exactly the target, split at random over the axes.
    task automatic send_norm(input int unsigned target);
        int unsigned lo;
        int unsigned hi;
        int unsigned a;
        int unsigned b;
        int unsigned rem;
        lo = (target > 65536) ? target - 65536 : 0;
        hi = (target < 32768) ? target : 32768;
        a = $urandom_range(hi, lo);
        rem = target - a;
        lo = (rem > 32768) ? rem - 32768 : 0;
        hi = (rem < 32768) ? rem : 32768;
        b = $urandom_range(hi, lo);
        send_sample(signed_axis(a), signed_axis(b), signed_axis(rem - b));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [16:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BASELINE:     base_r = value;
            CFG_STEP_MARGIN:  stepm_r = value[15:0];
            CFG_REARM_MARGIN: rearm_r = value[15:0];
            CFG_WINDOW_SIZE:
            begin
                win_r = value[6:0];
                clear_window();
            end
        endcase
        cfg_writes++;
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] data);
        step_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result item with no sample pending: %h", data);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (data[0])
            steps_seen++;
        if (data[0] !== want.step_now)
        begin
            $error("step_now: expected %0d, got %0d", want.step_now, data[0]);
            mismatch_count++;
        end
        if (data[32:1] !== want.step_total)
        begin
            $error("step_total: expected %0d, got %0d", want.step_total, data[32:1]);
            mismatch_count++;
        end
        if (data[35:33] !== want.level)
        begin
            $error("happiness_level: expected %0d, got %0d", want.level, data[35:33]);
            mismatch_count++;
        end
        if (data[39:36] !== 4'd0)
        begin
            $error("padding: expected 0, got %0d", data[39:36]);
            mismatch_count++;
        end
    endtask

    // Result side: checks accepted items and drives m_tready, including long hold-offs.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result(m_tdata);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(99, 0) < IDLE_PCT)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    task automatic test_extremes();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0001, 16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h0000, 16'h8000);
    endtask

    // A zero size acts as one, sizes above the ring depth act as the full depth,
    // and bits above the register width are dropped.
    task automatic test_window_limits();
        write_reg(CFG_WINDOW_SIZE, 17'd0);
        send_norm(NORM_MAX);
        send_norm(0);
        write_reg(CFG_WINDOW_SIZE, 17'd127);
        repeat (3) send_norm(NORM_MAX);
        write_reg(CFG_WINDOW_SIZE, 17'h10081);
        send_norm(NORM_MAX);
        send_norm(0);
        write_reg(CFG_WINDOW_SIZE, 17'd64);
        send_norm(NORM_MAX);
        send_norm(0);
        write_reg(CFG_WINDOW_SIZE, 17'd2);
        send_norm(NORM_MAX);
        send_norm(NORM_MAX);
        send_norm(0);
        send_norm(0);
    endtask

    // With the re-arm level above the step level, every sample counts a step and
    // re-arms at once; with the highest baseline no step is possible.
    task automatic test_margins();
        write_reg(CFG_BASELINE, 17'd0);
        write_reg(CFG_STEP_MARGIN, 17'h10000);
        write_reg(CFG_REARM_MARGIN, 17'h1FFFF);
        write_reg(CFG_WINDOW_SIZE, 17'd1);
        repeat (3) send_sample(16'h0001, 16'h0000, 16'h0000);
        write_reg(CFG_BASELINE, 17'h1FFFF);
        write_reg(CFG_STEP_MARGIN, 17'h0FFFF);
        send_norm(NORM_MAX);
        send_norm(NORM_MAX);
    endtask

    task automatic test_reward_saturation();
        write_reg(CFG_BASELINE, 17'd0);
        write_reg(CFG_STEP_MARGIN, 17'd0);
        write_reg(CFG_REARM_MARGIN, 17'd1);
        write_reg(CFG_WINDOW_SIZE, 17'd1);
        repeat (80)
        begin
            send_norm($urandom_range(NORM_MAX, 1));
            send_norm(0);
        end
    endtask

    function automatic int unsigned pick_norm(input bit go_high,
                                              input int unsigned hi_avg,
                                              input int unsigned lo_avg);
        int unsigned top;
        if (go_high)
        begin
            if (hi_avg >= NORM_MAX)
                return $urandom_range(NORM_MAX, 0);
            top = hi_avg + hi_avg / 4 + 256;
            if (top > NORM_MAX)
                top = NORM_MAX;
            return $urandom_range(top, hi_avg + 1);
        end
        if (lo_avg == 0)
            return 0;
        top = (lo_avg - 1 > NORM_MAX) ? NORM_MAX : lo_avg - 1;
        return $urandom_range(top, lo_avg / 2);
    endfunction

    // Alternating runs above the step level and below the re-arm level, with some
    // samples of pure noise mixed in.
    task automatic send_strides(input int strides);
        int unsigned n;
        int unsigned hi_avg;
        int unsigned lo_avg;
        int run;
        n = window_len();
        hi_avg = base_r + stepm_r;
        lo_avg = base_r + rearm_r;
        repeat (strides)
        begin
            for (int half = 0; half < 2; half++)
            begin
                run = $urandom_range(n + 1, 1);
                repeat (run)
                begin
                    if ($urandom_range(99, 0) < 10)
                        send_sample(16'($urandom), 16'($urandom), 16'($urandom));
                    else
                        send_norm(pick_norm(half == 0, hi_avg, lo_avg));
                end
            end
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_BASELINE, 17'd7424);
        write_reg(CFG_STEP_MARGIN, 17'd512);
        write_reg(CFG_REARM_MARGIN, 17'd256);
        write_reg(CFG_WINDOW_SIZE, 17'd4);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req = HOLD_CYCLES;
        send_strides(8);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random_walk(input int quota);
        int start;
        int phase;
        logic [16:0] value;
        start = items_sent;
        phase = 0;
        while (items_sent - start < quota)
        begin
            // Every fourth phase runs with both sides always ready.
            tx_idle_en = (phase % 4 != 3);
            rx_idle_en = tx_idle_en;
            case ($urandom_range(5, 0))
                0:       value = 17'd0;
                1:       value = 17'd7424;
                2:       value = 17'd98304;
                3:       value = 17'h1FFFF;
                default: value = $urandom_range(12000, 2000);
            endcase
            write_reg(CFG_BASELINE, value);
            for (int k = 0; k < 2; k++)
            begin
                case ($urandom_range(5, 0))
                    0:       value = 17'd0;
                    1:       value = 17'h0FFFF;
                    2:       value = 17'($urandom);
                    default: value = $urandom_range(2048, 0);
                endcase
                write_reg(k == 0 ? CFG_STEP_MARGIN : CFG_REARM_MARGIN, value);
            end
            if (phase == 0 || $urandom_range(2, 0) != 0)
            begin
                case ($urandom_range(9, 0))
                    0:       value = 17'd0;
                    1:       value = 17'd64;
                    2:       value = $urandom_range(127, 65);
                    3:       value = $urandom_range(20, 9);
                    default: value = $urandom_range(8, 1);
                endcase
                write_reg(CFG_WINDOW_SIZE, value);
            end
            send_strides(window_len() > 16 ? 2 : $urandom_range(12, 4));
            phase++;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BASELINE;
        cfg_data <= '0;
        base_r = 17'd7424;
        stepm_r = 16'd512;
        rearm_r = 16'd256;
        win_r = 7'd16;
        clear_window();
        disarmed = 1'b0;
        step_count = '0;
        mod15 = 0;
        reward = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_window_limits();
        test_margins();
        test_reward_saturation();
        test_backpressure();
        test_random_walk(RANDOM_ITEMS);

        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples across %0d register writes; checked %0d results, %0d steps.",
                 items_sent, cfg_writes, results_checked, steps_seen);
        $display("Covered window sizes 0 to 127, threshold extremes, reward cap and stalls.");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(2 * CLK_HALF * WATCHDOG_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
